// ----- src/drsc_pkg.sv -----
// Shared constants and controller/datapath interface types for the
// dual-reference sliding correlator. No dependencies.
`default_nettype none

package drsc_pkg;

  localparam int unsigned WINDOW      = 1024;
  localparam int unsigned IDX_W       = $clog2(WINDOW);
  localparam int unsigned FILL_W      = $clog2(WINDOW + 1);
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned PROD_W      = 2 * SAMPLE_W;
  localparam int unsigned ACC_W       = PROD_W + IDX_W;
  // Divide by WINDOW * 512.
  localparam int unsigned SCALE_SHIFT = IDX_W + 9;
  localparam logic [ACC_W-1:0] SCALE_BIAS = ACC_W'((64'd1 << SCALE_SHIFT) - 64'd1);

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic issue;       // read one window/reference pair and advance the index
    logic clear;       // restart index and accumulators
    logic ring_write;  // store a new signal sample
    logic ref_write;   // store one reference sample
    logic load_out;    // move the scaled sums into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic full_after;  // this signal sample completes the window
    logic last_index;  // index is at the final window position
    logic pipe_busy;   // reads or products still in flight
    logic out_free;    // output register can take a new result
  } dp_status_t;

endpackage

`default_nettype wire

// ----- src/drsc_datapath.sv -----
// Datapath of the sliding correlator: reference and window memories,
// shared multiply-accumulate pair, scaling and output register. Uses drsc_pkg.
`default_nettype none

module drsc_datapath (
  input  wire                         clk,
  input  wire                         rst,
  input  drsc_pkg::ctrl_cmd_t         cmd,
  output drsc_pkg::dp_status_t        status,
  input  wire                         ref_select,
  input  wire        [9:0]            ref_index,
  input  wire signed [15:0]           ref_value,
  input  wire signed [15:0]           sample,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic signed [15:0]          window_first_sample,
  output logic signed [15:0]          corr_zero,
  output logic signed [15:0]          corr_one
);

  logic signed [drsc_pkg::SAMPLE_W-1:0] ref0_mem [drsc_pkg::WINDOW];
  logic signed [drsc_pkg::SAMPLE_W-1:0] ref1_mem [drsc_pkg::WINDOW];
  logic signed [drsc_pkg::SAMPLE_W-1:0] ring_mem [drsc_pkg::WINDOW];

  logic [drsc_pkg::IDX_W-1:0]  wp;
  logic [drsc_pkg::FILL_W-1:0] fill;
  logic [drsc_pkg::IDX_W-1:0]  idx;
  logic [drsc_pkg::IDX_W:0]    raddr_sum;
  logic [drsc_pkg::IDX_W-1:0]  raddr;
  logic                        ref_in_range;

  logic signed [drsc_pkg::SAMPLE_W-1:0] ref0_q;
  logic signed [drsc_pkg::SAMPLE_W-1:0] ref1_q;
  logic signed [drsc_pkg::SAMPLE_W-1:0] ring_q;
  logic                                 rd_v;
  logic                                 first_q;
  logic signed [drsc_pkg::PROD_W-1:0]   prod0;
  logic signed [drsc_pkg::PROD_W-1:0]   prod1;
  logic                                 mul_v;
  logic signed [drsc_pkg::ACC_W-1:0]    acc0;
  logic signed [drsc_pkg::ACC_W-1:0]    acc1;
  logic signed [drsc_pkg::SAMPLE_W-1:0] oldest;
  logic [drsc_pkg::ACC_W-1:0]           biased0;
  logic [drsc_pkg::ACC_W-1:0]           biased1;

  assign ref_in_range = {1'b0, ref_index} < (drsc_pkg::IDX_W + 1)'(drsc_pkg::WINDOW);

  // Window position i sits at ring slot (wp + i) mod WINDOW.
  assign raddr_sum = {1'b0, wp} + {1'b0, idx};
  always_comb begin
    if (raddr_sum >= (drsc_pkg::IDX_W + 1)'(drsc_pkg::WINDOW)) begin
      raddr = drsc_pkg::IDX_W'(raddr_sum - (drsc_pkg::IDX_W + 1)'(drsc_pkg::WINDOW));
    end else begin
      raddr = raddr_sum[drsc_pkg::IDX_W-1:0];
    end
  end

  // Reference memories
  always_ff @(posedge clk) begin
    if (cmd.ref_write && ref_in_range && !ref_select) begin
      ref0_mem[ref_index[drsc_pkg::IDX_W-1:0]] <= ref_value;
    end
    if (cmd.issue) begin
      ref0_q <= ref0_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ref_write && ref_in_range && ref_select) begin
      ref1_mem[ref_index[drsc_pkg::IDX_W-1:0]] <= ref_value;
    end
    if (cmd.issue) begin
      ref1_q <= ref1_mem[idx];
    end
  end

  // Window ring
  always_ff @(posedge clk) begin
    if (cmd.ring_write) begin
      ring_mem[wp] <= sample;
    end
    if (cmd.issue) begin
      ring_q <= ring_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (cmd.ring_write) begin
      if (wp == drsc_pkg::IDX_W'(drsc_pkg::WINDOW - 1)) begin
        wp <= '0;
      end else begin
        wp <= wp + 1'b1;
      end
      if (fill < drsc_pkg::FILL_W'(drsc_pkg::WINDOW)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.clear) begin
      idx <= '0;
    end else if (cmd.issue) begin
      idx <= idx + 1'b1;
    end
  end

  // Read, multiply, accumulate stages
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v    <= 1'b0;
      first_q <= 1'b0;
      mul_v   <= 1'b0;
    end else begin
      rd_v    <= cmd.issue;
      first_q <= cmd.issue && (idx == '0);
      mul_v   <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    prod0 <= drsc_pkg::PROD_W'(ref0_q) * drsc_pkg::PROD_W'(ring_q);
    prod1 <= drsc_pkg::PROD_W'(ref1_q) * drsc_pkg::PROD_W'(ring_q);
    // The first window position read is the oldest sample.
    if (rd_v && first_q) begin
      oldest <= ring_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      acc0 <= '0;
      acc1 <= '0;
    end else if (mul_v) begin
      acc0 <= acc0 + drsc_pkg::ACC_W'(prod0);
      acc1 <= acc1 + drsc_pkg::ACC_W'(prod1);
    end
  end

  // Truncate toward zero: bias negative sums before the shift.
  assign biased0 = acc0 + (acc0[drsc_pkg::ACC_W-1] ? drsc_pkg::SCALE_BIAS : '0);
  assign biased1 = acc1 + (acc1[drsc_pkg::ACC_W-1] ? drsc_pkg::SCALE_BIAS : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      window_first_sample <= oldest;
      corr_zero <= biased0[drsc_pkg::SCALE_SHIFT + 15:drsc_pkg::SCALE_SHIFT];
      corr_one  <= biased1[drsc_pkg::SCALE_SHIFT + 15:drsc_pkg::SCALE_SHIFT];
    end
  end

  assign status.full_after = fill >= drsc_pkg::FILL_W'(drsc_pkg::WINDOW - 1);
  assign status.last_index = idx == drsc_pkg::IDX_W'(drsc_pkg::WINDOW - 1);
  assign status.pipe_busy  = rd_v || mul_v;
  assign status.out_free   = !out_valid || out_ready;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= drsc_pkg::FILL_W'(drsc_pkg::WINDOW))
    else $error("fill count above window length");

  a_load_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rd_v && !mul_v && status.out_free))
    else $error("result loaded while sums in flight or output occupied");

  a_issue_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (!cmd.load_out && !cmd.ring_write && !cmd.clear))
    else $error("read issued together with another command");

  a_wp_step: assert property (@(posedge clk) disable iff (rst)
    cmd.ring_write |=> ((wp == $past(wp) + 1'b1) ||
                        (wp == '0 && $past(wp) == drsc_pkg::IDX_W'(drsc_pkg::WINDOW - 1))))
    else $error("write pointer did not advance by one");

endmodule

`default_nettype wire

// ----- src/drsc_ctrl.sv -----
// Controller of the sliding correlator: accepts items and sequences the
// window walk, drain and result hand-off. Uses drsc_pkg.
`default_nettype none

module drsc_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire                   mode,
  input  drsc_pkg::dp_status_t  status,
  output drsc_pkg::ctrl_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_ready = state == S_IDLE;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (mode == drsc_pkg::MODE_SAMPLE) begin
            cmd.ring_write = 1'b1;
            if (status.full_after) begin
              cmd.clear  = 1'b1;
              state_next = S_RUN;
            end
          end else begin
            cmd.ref_write = 1'b1;
          end
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (status.last_index) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the previous result is taken.
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/dual_reference_sliding_correlator_unit.sv -----
// Top level of the dual-reference sliding correlator: joins controller and
// datapath. Uses drsc_pkg, drsc_ctrl and drsc_datapath.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------------
//   in      | in_valid / in_ready | mode, ref_select, ref_index, ref_value, sample
//   out     | out_valid/out_ready | window_first_sample, corr_zero, corr_one
//
// A load item or a signal item that leaves the window short is handled in the idle state.
// A signal item with a full window starts a walk: one shared multiply-accumulate
// pair walks all WINDOW positions, one ring read per cycle.
// Reset clears the write pointer, fill count and handshake state; memories hold.
// A result waiting in the output register does not block the next item; only
// the hand-off of the following result waits on out_ready.
`default_nettype none

module dual_reference_sliding_correlator_unit (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               mode,
  input  wire               ref_select,
  input  wire        [9:0]  ref_index,
  input  wire signed [15:0] ref_value,
  input  wire signed [15:0] sample,
  output logic              out_valid,
  input  wire               out_ready,
  output logic signed [15:0] window_first_sample,
  output logic signed [15:0] corr_zero,
  output logic signed [15:0] corr_one
);

  drsc_pkg::ctrl_cmd_t  cmd;
  drsc_pkg::dp_status_t status;

  drsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .status   (status),
    .cmd      (cmd)
  );

  drsc_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .ref_select          (ref_select),
    .ref_index           (ref_index),
    .ref_value           (ref_value),
    .sample              (sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .window_first_sample (window_first_sample),
    .corr_zero           (corr_zero),
    .corr_one            (corr_one)
  );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for dual_reference_sliding_correlator_unit: random valid/ready
// traffic with an in-line correlation predictor. Depends on drsc_pkg and the RTL in src/.

module testbench;

  localparam logic signed [15:0] S_MIN = 16'sh8000;
  localparam logic signed [15:0] S_MAX = 16'sh7FFF;
  localparam longint SCALE_DIV    = longint'(drsc_pkg::WINDOW) * 512;
  localparam int RANDOM_ITEMS     = 580;
  localparam int DRAIN_AT         = 300;
  localparam int TAIL_ITEMS       = 60;
  localparam int LONG_HOLD        = 5000;
  localparam int HOLD_AFTER       = 40;
  localparam int SETTLE_CYCLES    = drsc_pkg::WINDOW + 80;

  typedef struct {
    logic                                 md;
    logic                                 sel;
    logic [drsc_pkg::IDX_W-1:0]           idx;
    logic signed [drsc_pkg::SAMPLE_W-1:0] rv;
    logic signed [drsc_pkg::SAMPLE_W-1:0] smp;
    bit                                   drain;
  } corr_item_t;

  typedef struct {
    logic signed [drsc_pkg::SAMPLE_W-1:0] first_sample;
    logic signed [drsc_pkg::SAMPLE_W-1:0] corr0;
    logic signed [drsc_pkg::SAMPLE_W-1:0] corr1;
  } corr_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = drsc_pkg::MODE_LOAD;
  logic ref_select = 1'b0;
  logic [drsc_pkg::IDX_W-1:0] ref_index = '0;
  logic signed [drsc_pkg::SAMPLE_W-1:0] ref_value = '0;
  logic signed [drsc_pkg::SAMPLE_W-1:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [drsc_pkg::SAMPLE_W-1:0] window_first_sample;
  logic signed [drsc_pkg::SAMPLE_W-1:0] corr_zero;
  logic signed [drsc_pkg::SAMPLE_W-1:0] corr_one;

  // predictor state
  logic signed [drsc_pkg::SAMPLE_W-1:0] ref_mem [2][drsc_pkg::WINDOW];
  logic signed [drsc_pkg::SAMPLE_W-1:0] ring_mem [drsc_pkg::WINDOW];
  logic [drsc_pkg::IDX_W-1:0] ring_wr = '0;
  int unsigned ring_fill = 0;

  corr_item_t   pending_items[$];
  corr_result_t corr_expected[$];
  int  total_items = 0;
  int  items_taken = 0;
  int  results_due = 0;
  int  results_seen = 0;
  int  mismatch_count = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  logic tail_q = 1'b0;

  dual_reference_sliding_correlator_unit i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .mode                (mode),
    .ref_select          (ref_select),
    .ref_index           (ref_index),
    .ref_value           (ref_value),
    .sample              (sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .window_first_sample (window_first_sample),
    .corr_zero           (corr_zero),
    .corr_one            (corr_one)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #32_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    mismatch_count++;
  endtask

  // Window dot product against one reference, oldest ring slot first.
  function automatic logic signed [drsc_pkg::SAMPLE_W-1:0] scaled_dot(input bit sel);
    longint acc;
    longint q;
    logic [drsc_pkg::IDX_W-1:0] pos;
    acc = 0;
    pos = ring_wr;
    for (int k = 0; k < drsc_pkg::WINDOW; k++) begin
      acc += longint'(ref_mem[sel][k]) * longint'(ring_mem[pos]);
      pos++;
    end
    q = acc / SCALE_DIV;
    return q[drsc_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic advance_correlator(input logic md, input logic sel,
                                    input logic [drsc_pkg::IDX_W-1:0] idx,
                                    input logic signed [drsc_pkg::SAMPLE_W-1:0] rv,
                                    input logic signed [drsc_pkg::SAMPLE_W-1:0] smp);
    corr_result_t r;
    if (md == drsc_pkg::MODE_LOAD) begin
      ref_mem[sel][idx] = rv;
    end else begin
      ring_mem[ring_wr] = smp;
      ring_wr++;
      if (ring_fill < drsc_pkg::WINDOW) ring_fill++;
      if (ring_fill == drsc_pkg::WINDOW) begin
        r.first_sample = ring_mem[ring_wr];
        r.corr0        = scaled_dot(1'b0);
        r.corr1        = scaled_dot(1'b1);
        corr_expected.push_back(r);
      end
    end
  endtask

  function automatic logic signed [drsc_pkg::SAMPLE_W-1:0] pick_value();
    case ($urandom_range(0, 24))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      default: return drsc_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic push_load(input logic sel, input logic [drsc_pkg::IDX_W-1:0] idx,
                           input logic signed [drsc_pkg::SAMPLE_W-1:0] val);
    corr_item_t it;
    it.md    = drsc_pkg::MODE_LOAD;
    it.sel   = sel;
    it.idx   = idx;
    it.rv    = val;
    it.smp   = drsc_pkg::SAMPLE_W'($urandom);
    it.drain = 1'b0;
    pending_items.push_back(it);
    total_items++;
  endtask

  task automatic push_sample(input logic signed [drsc_pkg::SAMPLE_W-1:0] val);
    corr_item_t it;
    it.md    = drsc_pkg::MODE_SAMPLE;
    it.sel   = 1'($urandom);
    it.idx   = drsc_pkg::IDX_W'($urandom);
    it.rv    = drsc_pkg::SAMPLE_W'($urandom);
    it.smp   = val;
    it.drain = 1'b0;
    pending_items.push_back(it);
    total_items++;
  endtask

  // Stimulus, reset and end of run.
  initial begin
    // extreme references and an all-minimum window: the first result wraps
    for (int k = 0; k < drsc_pkg::WINDOW; k++)
      push_load(1'b0, drsc_pkg::IDX_W'(k), S_MIN);
    for (int k = 0; k < drsc_pkg::WINDOW; k++)
      push_load(1'b1, drsc_pkg::IDX_W'(k), S_MAX);
    for (int k = 0; k < drsc_pkg::WINDOW - 1; k++) push_sample(S_MIN);

    push_sample(S_MIN);
    push_sample(S_MAX);
    push_sample(16'sd0);
    push_sample(-16'sd1);
    push_sample(16'sd1);
    push_load(1'b0, '0, S_MAX);
    push_load(1'b1, drsc_pkg::IDX_W'(drsc_pkg::WINDOW - 1), S_MIN);
    push_load(1'b0, drsc_pkg::IDX_W'(drsc_pkg::WINDOW - 1), 16'sd0);
    push_load(1'b1, '0, 16'sd1);
    push_sample(S_MAX);
    push_sample(S_MIN);

    // fresh random references so the correlations spread out
    for (int k = 0; k < drsc_pkg::WINDOW; k++)
      push_load(1'b0, drsc_pkg::IDX_W'(k), drsc_pkg::SAMPLE_W'($urandom));
    for (int k = 0; k < drsc_pkg::WINDOW; k++)
      push_load(1'b1, drsc_pkg::IDX_W'(k), drsc_pkg::SAMPLE_W'($urandom));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 55) push_sample(pick_value());
      else push_load(1'($urandom), drsc_pkg::IDX_W'($urandom), pick_value());
      if (n == DRAIN_AT) pending_items[pending_items.size() - 1].drain = 1'b1;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (items_taken != total_items) @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (corr_expected.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", corr_expected.size()));
    end
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Input driver: hold each transfer until accepted, then pick the next one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      tail_q <= (pending_items.size() <= TAIL_ITEMS);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_items[0].drain && (in_valid || results_due != 0)) begin
          // pause until every outstanding result has been taken
          in_valid <= 1'b0;
        end else begin
          in_valid   <= 1'b1;
          mode       <= pending_items[0].md;
          ref_select <= pending_items[0].sel;
          ref_index  <= pending_items[0].idx;
          ref_value  <= pending_items[0].rv;
          sample     <= pending_items[0].smp;
          void'(pending_items.pop_front());
          if (!tail_q && $urandom_range(0, 99) < 8) gap_left = $urandom_range(1, 18);
        end
      end
    end
  end

  // Output side: random stall bursts plus one long hold-off to back up the block.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!tail_q && $urandom_range(0, 99) < 6) stall_left = $urandom_range(1, 18);
    end
  end

  // Monitor: check outputs first so a same-edge input cannot satisfy them.
  always @(posedge clk) begin
    corr_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (corr_expected.size() == 0) begin
          flag_mismatch("result with nothing expected");
        end else begin
          want = corr_expected.pop_front();
          if (window_first_sample !== want.first_sample)
            flag_mismatch($sformatf("window_first_sample got %0d want %0d",
                                    window_first_sample, want.first_sample));
          if (corr_zero !== want.corr0)
            flag_mismatch($sformatf("corr_zero got %0d want %0d", corr_zero, want.corr0));
          if (corr_one !== want.corr1)
            flag_mismatch($sformatf("corr_one got %0d want %0d", corr_one, want.corr1));
        end
        results_seen <= results_seen + 1;
      end
      if (in_valid && in_ready) begin
        advance_correlator(mode, ref_select, ref_index, ref_value, sample);
        items_taken <= items_taken + 1;
      end
      results_due <= corr_expected.size();
    end
  end

endmodule
